// ===== sv/swtq_pkg.sv =====
// Shared types and constants of the sorted wakeup timer queue.
`default_nettype none

package swtq_pkg;

    // Widths fixed by the beat formats.
    localparam int unsigned TICK_W = 32;
    localparam int unsigned TID_W  = 8;
    // Slot ids stored in the queue cells cover the largest supported pool.
    localparam int unsigned ID_W   = 6;
    localparam int unsigned SLOT_COUNT_DEF = 8;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_SET    = 2'd1,
        OP_STOP   = 2'd2,
        OP_DELETE = 2'd3
    } op_e_t;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_BAD_ID = 2'd1,
        RES_IN_USE = 2'd2
    } result_e_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_INSERT = 2'd2
    } cell_op_e_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_REMOVE  = 2'd1,
        ST_INSERT  = 2'd2,
        ST_RESPOND = 2'd3
    } state_e_t;

    typedef struct packed {
        op_e_t               operation;
        logic [TID_W-1:0]    timer_id;
        logic [TICK_W-1:0]   now_tick;
        logic [TICK_W-1:0]   interval;
    } in_beat_t;

    typedef struct packed {
        result_e_t           result_code;
        logic                head_valid;
        logic [2:0]          head_slot;
        logic [TICK_W-1:0]   head_expiry;
        logic [3:0]          free_count;
    } out_beat_t;

    // One queue position: a slot id and its expiry tick.
    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [TICK_W-1:0]   expiry;
    } entry_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_e_t          op;
        logic [ID_W-1:0]     key;
        logic [TICK_W-1:0]   expiry;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/swtq_cell.sv =====
// One position of the expiry-ordered queue row.
`default_nettype none

module swtq_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire swtq_pkg::cell_cmd_t    cmd,
    input  wire swtq_pkg::entry_t       left_entry,
    input  wire logic                   left_greater,
    input  wire logic                   left_hit,
    input  wire swtq_pkg::entry_t       right_entry,
    output swtq_pkg::entry_t            entry,
    output logic                        greater,
    output logic                        hit
);

    swtq_pkg::entry_t entry_reg;
    swtq_pkg::entry_t entry_next;
    swtq_pkg::entry_t new_entry;

    // Empty positions sort after every queued timer.
    assign greater = !entry_reg.valid || (entry_reg.expiry > cmd.expiry);
    assign hit     = left_hit || (entry_reg.valid && (entry_reg.id == cmd.key));
    assign entry   = entry_reg;

    always_comb
    begin
        new_entry.valid  = 1'b1;
        new_entry.id     = cmd.key;
        new_entry.expiry = cmd.expiry;
        entry_next       = entry_reg;
        unique case (cmd.op)
            swtq_pkg::CMD_REMOVE:
            begin
                // The removed entry and everything behind it move one place forward.
                if (hit)
                begin
                    entry_next = right_entry;
                end
            end
            swtq_pkg::CMD_INSERT:
            begin
                if (left_greater)
                begin
                    entry_next = left_entry;
                end
                else if (greater)
                begin
                    entry_next = new_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sorted_wakeup_timer_queue.sv =====
// Top level of the sorted wakeup timer queue: control and the row of queue cells.
`default_nettype none

// Channel   Handshake             Payload    Direction
// -------   -------------------   --------   ---------
// in        in_valid/in_stall     in_beat    request beat into the block
// out       out_valid/out_stall   out_beat   one result beat per request
//
// A create, stop or delete beat passes the remove and respond states before
// the next acceptance, a set beat insert too; the cell row passes (remove, then
// insert) are one state each. A stalled result holds the last step until taken.
// Reset clears the queue row, marks every slot free and empties the output.

module sorted_wakeup_timer_queue #(
    parameter int unsigned SLOT_COUNT = swtq_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire swtq_pkg::in_beat_t   in_beat,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output swtq_pkg::out_beat_t       out_beat
);

    localparam int unsigned FREE_W = $clog2(SLOT_COUNT + 1);
    localparam int unsigned FREE_X = (FREE_W > 4) ? FREE_W : 4;

    // Control state.
    swtq_pkg::state_e_t        state_reg, state_next;
    logic [SLOT_COUNT-1:0]     created_reg, created_next;
    logic [FREE_W-1:0]         free_reg, free_next;
    logic                      out_valid_reg, out_valid_next;

    // Request and result payload.
    swtq_pkg::op_e_t           op_reg, op_next;
    logic [swtq_pkg::TID_W-1:0]  id_reg, id_next;
    logic [swtq_pkg::TICK_W-1:0] expiry_reg, expiry_next;
    swtq_pkg::result_e_t       code_reg, code_next;
    swtq_pkg::out_beat_t       out_reg, out_next;

    // Cell row wiring.
    swtq_pkg::cell_cmd_t       cmd;
    swtq_pkg::entry_t          entries [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]     greaters;
    logic [SLOT_COUNT-1:0]     hits;

    logic                      in_range;
    logic                      created_hit;
    logic [FREE_X-1:0]         free_ext;

    assign in_stall  = (state_reg != swtq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;
    assign free_ext  = FREE_X'(free_next);

    // The row: each cell sees its neighbors' contents and the shift flags
    // that ripple from the head toward the tail.
    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            swtq_pkg::entry_t left_e, right_e;
            logic             left_g, left_h;
            if (g == 0)
            begin : g_first
                assign left_e = '0;
                assign left_g = 1'b0;
                assign left_h = 1'b0;
            end
            else
            begin : g_inner
                assign left_e = entries[g-1];
                assign left_g = greaters[g-1];
                assign left_h = hits[g-1];
            end
            if (g == SLOT_COUNT - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = entries[g+1];
            end
            swtq_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .left_entry   (left_e),
                .left_greater (left_g),
                .left_hit     (left_h),
                .right_entry  (right_e),
                .entry        (entries[g]),
                .greater      (greaters[g]),
                .hit          (hits[g])
            );
        end
    endgenerate

    // Slot lookup: range check and whether the slot has been created.
    always_comb
    begin
        in_range    = (id_reg < swtq_pkg::TID_W'(SLOT_COUNT));
        created_hit = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (id_reg == swtq_pkg::TID_W'(i))
            begin
                created_hit = created_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        created_next   = created_reg;
        free_next      = free_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        expiry_next    = expiry_reg;
        code_next      = code_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd.op     = swtq_pkg::CMD_HOLD;
        cmd.key    = id_reg[swtq_pkg::ID_W-1:0];
        cmd.expiry = expiry_reg;

        unique case (state_reg)
            swtq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_beat.operation;
                    id_next     = in_beat.timer_id;
                    expiry_next = in_beat.now_tick + in_beat.interval;
                    state_next  = swtq_pkg::ST_REMOVE;
                end
            end
            swtq_pkg::ST_REMOVE:
            begin
                state_next = swtq_pkg::ST_RESPOND;
                code_next  = swtq_pkg::RES_OK;
                if (!in_range)
                begin
                    code_next = swtq_pkg::RES_BAD_ID;
                end
                else if (op_reg == swtq_pkg::OP_CREATE)
                begin
                    if (created_hit)
                    begin
                        code_next = swtq_pkg::RES_IN_USE;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (id_reg == swtq_pkg::TID_W'(i))
                            begin
                                created_next[i] = 1'b1;
                            end
                        end
                        free_next = free_reg - FREE_W'(1);
                    end
                end
                else if (!created_hit)
                begin
                    code_next = swtq_pkg::RES_BAD_ID;
                end
                else
                begin
                    // Set, stop and delete all take the slot out of the queue
                    // first; a slot that is not queued matches no cell.
                    cmd.op = swtq_pkg::CMD_REMOVE;
                    if (op_reg == swtq_pkg::OP_SET)
                    begin
                        state_next = swtq_pkg::ST_INSERT;
                    end
                    else if (op_reg == swtq_pkg::OP_DELETE)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (id_reg == swtq_pkg::TID_W'(i))
                            begin
                                created_next[i] = 1'b0;
                            end
                        end
                        free_next = free_reg + FREE_W'(1);
                    end
                end
            end
            swtq_pkg::ST_INSERT:
            begin
                // New timer goes behind every queued timer with an equal expiry.
                cmd.op     = swtq_pkg::CMD_INSERT;
                state_next = swtq_pkg::ST_RESPOND;
            end
            swtq_pkg::ST_RESPOND:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_next.result_code = code_reg;
                    out_next.head_valid  = entries[0].valid;
                    out_next.head_slot   = entries[0].valid ? entries[0].id[2:0] : 3'd0;
                    out_next.head_expiry = entries[0].valid ? entries[0].expiry
                                                            : '0;
                    out_next.free_count  = free_ext[3:0];
                    out_valid_next       = 1'b1;
                    state_next           = swtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swtq_pkg::ST_IDLE;
            created_reg   <= '0;
            free_reg      <= FREE_W'(SLOT_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            created_reg   <= created_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        expiry_reg <= expiry_next;
        code_reg   <= code_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_sorted_wakeup_timer_queue.sv =====
// Self-checking testbench of the sorted wakeup timer queue with a cycle-free slot and queue predictor.
`timescale 1ns / 1ps

module tb_sorted_wakeup_timer_queue;

    localparam int unsigned SLOTS = swtq_pkg::SLOT_COUNT_DEF;
    // Longest idle run that the sender inserts before a beat.
    localparam int unsigned MAX_GAP = 20;
    // Settling time after the last result.
    localparam int unsigned TAIL_CYCLES = 20;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_INACTIVE = 2'd1,
        SLOT_ACTIVE   = 2'd2
    } slot_state_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    swtq_pkg::in_beat_t  in_beat   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    swtq_pkg::out_beat_t out_beat;

    // Predicted state of the timer pool and of the expiry-ordered queue.
    slot_state_t  slot_state [SLOTS];
    logic [31:0]  slot_expiry [SLOTS];
    int unsigned  wake_order [SLOTS];
    int unsigned  queued_count;
    int unsigned  free_slots;

    // Status beats that the block still owes, oldest first.
    swtq_pkg::out_beat_t awaited_status [$];
    int unsigned  mismatch_count = 0;

    // Idle percentages of the sender and of the receiver in the current phase.
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_stall_pct = 0;

    sorted_wakeup_timer_queue #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_beat (out_beat)
    );

    always #6 clk = ~clk;

    // Applies one request to the predicted pool and returns the status beat that it
    // must produce. Rejected requests leave the pool untouched.
    function automatic swtq_pkg::out_beat_t predict_timer_step(input swtq_pkg::in_beat_t req);
        swtq_pkg::out_beat_t rsp;
        int unsigned id;
        int unsigned pos;
        int unsigned k;
        logic [31:0] due;
        rsp = '0;
        rsp.result_code = swtq_pkg::RES_OK;
        id = {24'd0, req.timer_id};
        if (id >= SLOTS)
        begin
            rsp.result_code = swtq_pkg::RES_BAD_ID;
        end
        else if (req.operation == swtq_pkg::OP_CREATE)
        begin
            if (slot_state[id] != SLOT_FREE)
            begin
                rsp.result_code = swtq_pkg::RES_IN_USE;
            end
            else
            begin
                slot_state[id] = SLOT_INACTIVE;
                if (free_slots > 0) free_slots--;
            end
        end
        else if (slot_state[id] == SLOT_FREE)
        begin
            rsp.result_code = swtq_pkg::RES_BAD_ID;
        end
        else
        begin
            // Set, stop and delete all first take an active slot out of the queue.
            if (slot_state[id] == SLOT_ACTIVE)
            begin
                for (pos = 0; pos < queued_count; pos++)
                begin
                    if (wake_order[pos] == id) break;
                end
                for (k = pos; k + 1 < queued_count; k++) wake_order[k] = wake_order[k + 1];
                if (pos < queued_count) queued_count--;
            end
            if (req.operation == swtq_pkg::OP_SET)
            begin
                // The expiry wraps at 32 bits; the insertion point is after every
                // queued slot whose expiry is less than or equal to the new one.
                due = req.now_tick + req.interval;
                slot_expiry[id] = due;
                pos = 0;
                while (pos < queued_count && slot_expiry[wake_order[pos]] <= due) pos++;
                for (k = queued_count; k > pos; k--) wake_order[k] = wake_order[k - 1];
                wake_order[pos] = id;
                queued_count++;
                slot_state[id] = SLOT_ACTIVE;
            end
            else if (req.operation == swtq_pkg::OP_STOP)
            begin
                slot_state[id] = SLOT_INACTIVE;
            end
            else
            begin
                slot_state[id] = SLOT_FREE;
                if (free_slots < SLOTS) free_slots++;
            end
        end
        if (queued_count > 0)
        begin
            rsp.head_valid  = 1'b1;
            rsp.head_slot   = wake_order[0][2:0];
            rsp.head_expiry = slot_expiry[wake_order[0]];
        end
        rsp.free_count = free_slots[3:0];
        return rsp;
    endfunction

    // Sends one request beat. The sender may idle before it; valid stays high
    // from one beat to the next when there is no gap, so it is never dropped and
    // raised again in the same step.
    task automatic send_request(input swtq_pkg::in_beat_t req);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= req;
        do @(posedge clk); while (in_stall);
        awaited_status.push_back(predict_timer_step(req));
    endtask

    task automatic send_op(input swtq_pkg::op_e_t op, input int unsigned id,
                           input logic [31:0] now, input logic [31:0] ivl);
        swtq_pkg::in_beat_t req;
        req.operation = op;
        req.timer_id  = id[7:0];
        req.now_tick  = now;
        req.interval  = ivl;
        send_request(req);
    endtask

    // Holds the sender off until every owed status beat has been taken. Valid is
    // dropped before the wait, so a following send starts in a new step.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_status.size() != 0);
    endtask

    // Ids out of range for every operation, and operations on slots never created.
    task automatic test_id_checks();
        send_op(swtq_pkg::OP_CREATE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(swtq_pkg::OP_SET,    SLOTS, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_STOP,   128, 32'h1234_5678, 32'd1);
        send_op(swtq_pkg::OP_DELETE, 200, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_SET,    0, 32'd10, 32'd10);
        send_op(swtq_pkg::OP_STOP,   1, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_DELETE, SLOTS - 1, 32'd0, 32'd0);
    endtask

    // Create, create again on a used slot, stop on an inactive slot, delete on
    // inactive and active slots, and the free count running down to zero and back.
    task automatic test_slot_lifecycle();
        int unsigned i;
        send_op(swtq_pkg::OP_CREATE, 0, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_CREATE, 0, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_STOP,   0, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_DELETE, 0, 32'd0, 32'd0);
        for (i = 0; i < SLOTS; i++) send_op(swtq_pkg::OP_CREATE, i, $urandom, $urandom);
        send_op(swtq_pkg::OP_SET,    5, 32'd1000, 32'd5);
        send_op(swtq_pkg::OP_DELETE, 5, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_CREATE, 5, 32'd0, 32'd0);
    endtask

    // Ordering: equal expiries keep their arrival order, a re-set moves a slot,
    // extreme ticks wrap and the wrapped expiry sorts ahead of larger ones.
    task automatic test_expiry_order();
        send_op(swtq_pkg::OP_SET,  2, 32'd100, 32'd50);
        send_op(swtq_pkg::OP_SET,  3, 32'd140, 32'd10);
        send_op(swtq_pkg::OP_SET,  2, 32'd200, 32'd0);
        send_op(swtq_pkg::OP_STOP, 3, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_STOP, 3, 32'd0, 32'd0);
        send_op(swtq_pkg::OP_SET,  0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(swtq_pkg::OP_SET,  1, 32'hFFFF_FFF0, 32'h0000_0020);
        send_op(swtq_pkg::OP_SET,  4, 32'd0, 32'd0);
    endtask

    // Random traffic in one idling phase. Requests mostly target valid slots
    // so that the queue fills and drains; some use tiny ticks to force equal
    // expiries and some start near the top of the tick range to force a wrap.
    task automatic test_random_traffic(input int unsigned count,
                                       input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        swtq_pkg::in_beat_t req;
        int unsigned n;
        int unsigned pick;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)      req.operation = swtq_pkg::OP_CREATE;
            else if (pick < 60) req.operation = swtq_pkg::OP_SET;
            else if (pick < 75) req.operation = swtq_pkg::OP_STOP;
            else                req.operation = swtq_pkg::OP_DELETE;
            if ($urandom_range(99) < 8) req.timer_id = 8'($urandom_range(255, SLOTS));
            else                        req.timer_id = 8'($urandom_range(SLOTS - 1, 0));
            case ($urandom_range(3))
                0:
                begin
                    req.now_tick = $urandom_range(3);
                    req.interval = $urandom_range(3);
                end
                1:
                begin
                    req.now_tick = $urandom;
                    req.interval = $urandom;
                end
                2:
                begin
                    req.now_tick = $urandom;
                    req.interval = $urandom_range(7);
                end
                default:
                begin
                    req.now_tick = 32'hFFFF_FFC0 | $urandom_range(63);
                    req.interval = $urandom_range(127);
                end
            endcase
            send_request(req);
        end
        wait_for_results();
    endtask

    // The receiver stalls at random with the percentage of the current phase.
    always @(posedge clk)
    begin
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end

    // Every status beat taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        swtq_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_status.size() == 0)
            begin
                $error("status beat with no request pending");
                mismatch_count++;
            end
            else
            begin
                want = awaited_status.pop_front();
                if (out_beat.result_code !== want.result_code)
                begin
                    $error("result_code: expected %0d, actual %0d",
                           want.result_code, out_beat.result_code);
                    mismatch_count++;
                end
                if (out_beat.head_valid !== want.head_valid)
                begin
                    $error("head_valid: expected %0d, actual %0d",
                           want.head_valid, out_beat.head_valid);
                    mismatch_count++;
                end
                if (out_beat.head_slot !== want.head_slot)
                begin
                    $error("head_slot: expected %0d, actual %0d",
                           want.head_slot, out_beat.head_slot);
                    mismatch_count++;
                end
                if (out_beat.head_expiry !== want.head_expiry)
                begin
                    $error("head_expiry: expected %0h, actual %0h",
                           want.head_expiry, out_beat.head_expiry);
                    mismatch_count++;
                end
                if (out_beat.free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, actual %0d",
                           want.free_count, out_beat.free_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned i;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_state[i]  = SLOT_FREE;
            slot_expiry[i] = '0;
            wake_order[i]  = 0;
        end
        queued_count = 0;
        free_slots   = SLOTS;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_id_checks();
        test_slot_lifecycle();
        test_expiry_order();
        wait_for_results();

        test_random_traffic(110, 0, 0);
        test_random_traffic(130, 66, 0);
        test_random_traffic(130, 0, 66);
        test_random_traffic(150, 7, 7);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_status.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of all phases.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/swtq_pkg.sv
sv/swtq_cell.sv
sv/sorted_wakeup_timer_queue.sv
tb/tb_sorted_wakeup_timer_queue.sv
